// ----- sv/pclp_pkg.sv -----
// ----------------------------------------------------------------------------
// PLA cube parser package
// Shared types, defaults, register indexes and character codes.
// ----------------------------------------------------------------------------
package pclp_pkg;

  // Default size limits
  localparam int DEF_MAX_INPUTS  = 32;
  localparam int DEF_MAX_OUTPUTS = 32;

  // Count register width
  localparam int CNT_W = 6;

  // Configuration register indexes
  localparam logic [2:0] CFG_NUM_INPUTS  = 3'd0;
  localparam logic [2:0] CFG_NUM_OUTPUTS = 3'd1;
  localparam logic [2:0] CFG_KEEP_ONSET  = 3'd2;
  localparam logic [2:0] CFG_KEEP_OFFSET = 3'd3;
  localparam logic [2:0] CFG_KEEP_DCSET  = 3'd4;

  // Configuration reset values
  localparam logic [CNT_W-1:0] RST_NUM_INPUTS  = 6'd8;
  localparam logic [CNT_W-1:0] RST_NUM_OUTPUTS = 6'd8;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Parser phase
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_IN   = 4'b0010,
    PH_OUT  = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_e;

  // One input item
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } item_t;

  // Configuration registers
  typedef struct packed {
    logic [CNT_W-1:0] num_inputs;
    logic [CNT_W-1:0] num_outputs;
    logic             keep_onset;
    logic             keep_offset;
    logic             keep_dcset;
  } cfg_t;

  // Map a count of zero to one and limit it to the maximum
  function automatic logic [CNT_W-1:0] clamp_count(logic [CNT_W-1:0] v,
                                                   logic [CNT_W-1:0] mx);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > mx) begin
      r = mx;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/pclp_in_stage.sv -----
// ----------------------------------------------------------------------------
// PLA cube parser input stage
// Registers one incoming item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module pclp_in_stage
  import pclp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Stall only while a held item is not taken this cycle
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the item on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- sv/pclp_core.sv -----
// ----------------------------------------------------------------------------
// PLA cube parser core
// Parser state, one-pass character decode and the registered result.
// ----------------------------------------------------------------------------
module pclp_core
  import pclp_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    item_valid_i,
  input  item_t                   item_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2*MAX_INPUTS-1:0] input_part_o,
  output logic [MAX_OUTPUTS-1:0]  onset_mask_o,
  output logic [MAX_OUTPUTS-1:0]  offset_mask_o,
  output logic [MAX_OUTPUTS-1:0]  dcset_mask_o,
  output logic                    add_onset_o,
  output logic                    add_offset_o,
  output logic                    add_dcset_o,
  output logic                    line_ignored_o
);

  localparam int IW = 2 * MAX_INPUTS;
  localparam int OW = MAX_OUTPUTS;
  localparam int MAX_POS = (MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS;

  // Parser state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [IW-1:0]    in_bits_q, in_bits_d;
  logic [OW-1:0]    on_q, on_d, off_q, off_d, dc_q, dc_d;
  logic [2:0]       keep_q, keep_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  logic [IW-1:0]    res_in_q;
  logic [OW-1:0]    res_on_q, res_off_q, res_dc_q;
  logic [2:0]       res_add_q;
  logic             res_bad_q;

  // Decode signals
  logic [7:0]       c;
  logic [CNT_W-1:0] ni, no;
  logic [CNT_W-1:0] pos_eff, pos_inc;
  logic [IW-1:0]    in_bits_eff;
  logic [OW-1:0]    on_eff, off_eff, dc_eff;
  logic [2:0]       keep_eff;
  logic             blank, start, work, emit, bad;
  logic             set_lo, set_hi, set_on, set_off, set_dc, known;
  logic [MAX_INPUTS-1:0] in_sel;
  logic [OW-1:0]    out_sel;

  assign c  = item_i.char_in;
  assign ni = clamp_count(cfg_i.num_inputs, CNT_W'(MAX_INPUTS));
  assign no = clamp_count(cfg_i.num_outputs, CNT_W'(MAX_OUTPUTS));

  assign blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
                 (c == CH_VT) || (c == CH_FF) || (c == CH_CR);

  // Take the held item when the result slot is free or draining
  assign take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  // Classify the phase and the character
  always_comb begin
    start = 1'b0;
    work  = 1'b0;
    if (!item_i.end_of_input) begin
      unique case (phase_q)
        PH_IDLE: start = !blank && (c != CH_HASH) && (c != CH_DOT);
        PH_IN:   work  = 1'b1;
        PH_OUT:  work  = 1'b1;
        PH_SKIP: work  = 1'b0;
        default: work  = 1'b0;
      endcase
    end
  end

  // Start of a cube clears the working values
  assign pos_eff     = start ? '0 : pos_q;
  assign in_bits_eff = start ? '0 : in_bits_q;
  assign on_eff      = start ? '0 : on_q;
  assign off_eff     = start ? '0 : off_q;
  assign dc_eff      = start ? '0 : dc_q;
  assign keep_eff    = start ? '0 : keep_q;
  assign pos_inc     = pos_eff + CNT_W'(1);

  // Decode input-part characters
  always_comb begin
    set_lo = 1'b0;
    set_hi = 1'b0;
    known  = 1'b1;
    case (c) inside
      CH_TWO, CH_DASH: begin
        set_lo = 1'b1;
        set_hi = 1'b1;
      end
      CH_ZERO:  set_lo = 1'b1;
      CH_ONE:   set_hi = 1'b1;
      CH_QUEST: known  = 1'b1;
      default:  known  = 1'b0;
    endcase
    if (phase_q == PH_OUT && !start) begin
      // Output-part characters, each gated by its keep flag
      set_lo = 1'b0;
      set_hi = 1'b0;
      known  = 1'b1;
      case (c) inside
        CH_FOUR, CH_ONE:   known = 1'b1;
        CH_THREE, CH_ZERO: known = 1'b1;
        CH_TWO, CH_DASH:   known = 1'b1;
        CH_TILDE:          known = 1'b1;
        default:           known = 1'b0;
      endcase
    end
  end

  always_comb begin
    set_on  = 1'b0;
    set_off = 1'b0;
    set_dc  = 1'b0;
    case (c) inside
      CH_FOUR, CH_ONE:   set_on  = cfg_i.keep_onset;
      CH_THREE, CH_ZERO: set_off = cfg_i.keep_offset;
      CH_TWO, CH_DASH:   set_dc  = cfg_i.keep_dcset;
      default:           set_on  = 1'b0;
    endcase
  end

  // Position select lanes
  always_comb begin
    for (int v = 0; v < MAX_INPUTS; v++) begin
      in_sel[v] = (pos_eff == CNT_W'(v)) && (pos_eff < ni);
    end
    for (int v = 0; v < OW; v++) begin
      out_sel[v] = (pos_eff == CNT_W'(v)) && (pos_eff < no);
    end
  end

  // Next state and result
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    in_bits_d = in_bits_q;
    on_d      = on_q;
    off_d     = off_q;
    dc_d      = dc_q;
    keep_d    = keep_q;
    emit      = 1'b0;
    bad       = 1'b0;
    if (item_i.end_of_input) begin
      phase_d = PH_IDLE;
      pos_d   = '0;
      if (phase_q == PH_IN || phase_q == PH_OUT) begin
        emit = 1'b1;
        bad  = 1'b1;
      end
    end else if (phase_q == PH_SKIP) begin
      if (c == CH_NL) begin
        phase_d = PH_IDLE;
      end
    end else if (phase_q == PH_IDLE && !start) begin
      if (!blank) begin
        phase_d = PH_SKIP;
      end
    end else if (start || work) begin
      if (start) begin
        phase_d   = PH_IN;
        pos_d     = '0;
        in_bits_d = '0;
        on_d      = '0;
        off_d     = '0;
        dc_d      = '0;
        keep_d    = '0;
      end
      if (!blank && c != CH_BAR) begin
        if (!known) begin
          phase_d = PH_SKIP;
          emit    = 1'b1;
          bad     = 1'b1;
        end else if (start || phase_q == PH_IN) begin
          for (int v = 0; v < MAX_INPUTS; v++) begin
            in_bits_d[2*v]   = in_bits_eff[2*v]   | (in_sel[v] & set_lo);
            in_bits_d[2*v+1] = in_bits_eff[2*v+1] | (in_sel[v] & set_hi);
          end
          if (pos_inc >= ni) begin
            phase_d = PH_OUT;
            pos_d   = '0;
          end else begin
            phase_d = PH_IN;
            pos_d   = pos_inc;
          end
        end else begin
          on_d   = on_eff  | (out_sel & {OW{set_on}});
          off_d  = off_eff | (out_sel & {OW{set_off}});
          dc_d   = dc_eff  | (out_sel & {OW{set_dc}});
          keep_d = keep_eff | {set_dc, set_off, set_on};
          if (pos_inc >= no) begin
            phase_d = PH_IDLE;
            pos_d   = '0;
            emit    = 1'b1;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
    end
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pos_q     <= '0;
      in_bits_q <= '0;
      on_q      <= '0;
      off_q     <= '0;
      dc_q      <= '0;
      keep_q    <= '0;
    end else if (take_o) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      in_bits_q <= in_bits_d;
      on_q      <= on_d;
      off_q     <= off_d;
      dc_q      <= dc_d;
      keep_q    <= keep_d;
    end
  end

  // Result valid: set on emit, drop once taken
  always_comb begin
    if (take_o && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load result payload; an error result carries zeros
  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_in_q  <= bad ? '0 : in_bits_d;
      res_on_q  <= bad ? '0 : on_d;
      res_off_q <= bad ? '0 : off_d;
      res_dc_q  <= bad ? '0 : dc_d;
      res_add_q <= bad ? '0 : keep_d;
      res_bad_q <= bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign input_part_o   = res_in_q;
  assign onset_mask_o   = res_on_q;
  assign offset_mask_o  = res_off_q;
  assign dcset_mask_o   = res_dc_q;
  assign add_onset_o    = res_add_q[0];
  assign add_offset_o   = res_add_q[1];
  assign add_dcset_o    = res_add_q[2];
  assign line_ignored_o = res_bad_q;

  // An error result carries no cube
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_bad_q |-> (res_in_q == '0) && (res_on_q == '0) &&
      (res_off_q == '0) && (res_dc_q == '0) && (res_add_q == '0))
    else $error("error result carries cube data");

  // Inside a cube the position stays within the largest part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IN) || (phase_q == PH_OUT) |-> pos_q < CNT_W'(MAX_POS))
    else $error("cube position out of range");

  // End of input always returns the parser to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && item_i.end_of_input |=> phase_q == PH_IDLE)
    else $error("end of input did not return to idle");

  // A bad character drops the rest of the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && emit && bad && !item_i.end_of_input |=> phase_q == PH_SKIP)
    else $error("bad character did not skip the line");

endmodule

// ----- sv/pla_cube_line_parser.sv -----
// ----------------------------------------------------------------------------
// PLA cube line parser
// Reads PLA text one byte per item and returns one result per finished or dropped cube.
// ----------------------------------------------------------------------------
// An item is held in the input register; the core then loads the result register.
// Throughput: one character per cycle unless a waiting result is stalled; the
//   input and result registers let a new item enter while a result waits to be taken.
// Reset: configuration returns to its defaults and the parser to idle.
module pla_cube_line_parser
  import pclp_pkg::*;
#(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [CNT_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              char_in_i,
  input  logic                    end_of_input_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2*MAX_INPUTS-1:0] input_part_o,
  output logic [MAX_OUTPUTS-1:0]  onset_mask_o,
  output logic [MAX_OUTPUTS-1:0]  offset_mask_o,
  output logic [MAX_OUTPUTS-1:0]  dcset_mask_o,
  output logic                    add_onset_o,
  output logic                    add_offset_o,
  output logic                    add_dcset_o,
  output logic                    line_ignored_o
);

  cfg_t  cfg_q;
  item_t item_in, item_held;
  logic  item_valid, take;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_inputs  <= RST_NUM_INPUTS;
      cfg_q.num_outputs <= RST_NUM_OUTPUTS;
      cfg_q.keep_onset  <= 1'b1;
      cfg_q.keep_offset <= 1'b0;
      cfg_q.keep_dcset  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_INPUTS:  cfg_q.num_inputs  <= cfg_data_i;
        CFG_NUM_OUTPUTS: cfg_q.num_outputs <= cfg_data_i;
        CFG_KEEP_ONSET:  cfg_q.keep_onset  <= cfg_data_i[0];
        CFG_KEEP_OFFSET: cfg_q.keep_offset <= cfg_data_i[0];
        CFG_KEEP_DCSET:  cfg_q.keep_dcset  <= cfg_data_i[0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  assign item_in.char_in      = char_in_i;
  assign item_in.end_of_input = end_of_input_i;

  pclp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item_in),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item_held)
  );

  pclp_core #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (item_valid),
    .item_i         (item_held),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .input_part_o   (input_part_o),
    .onset_mask_o   (onset_mask_o),
    .offset_mask_o  (offset_mask_o),
    .dcset_mask_o   (dcset_mask_o),
    .add_onset_o    (add_onset_o),
    .add_offset_o   (add_offset_o),
    .add_dcset_o    (add_dcset_o),
    .line_ignored_o (line_ignored_o)
  );

endmodule

// ----- verif/pla_cube_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PLA cube checker
// Watches the configuration port and both item channels of the cube parser,
// predicts each finished or dropped cube and compares the results field by
// field in order.
// ----------------------------------------------------------------------------
module pla_cube_checker
  import pclp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [7:0]       char_in_i,
  input  logic             end_of_input_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [63:0]      input_part_i,
  input  logic [31:0]      onset_mask_i,
  input  logic [31:0]      offset_mask_i,
  input  logic [31:0]      dcset_mask_i,
  input  logic             add_onset_i,
  input  logic             add_offset_i,
  input  logic             add_dcset_i,
  input  logic             line_ignored_i,
  output int               cubes_due_o,
  output int               mismatches_o
);

  localparam int unsigned INPUT_LIMIT  = DEF_MAX_INPUTS;
  localparam int unsigned OUTPUT_LIMIT = DEF_MAX_OUTPUTS;

  // One expected result
  typedef struct packed {
    logic [63:0] input_part;
    logic [31:0] onset;
    logic [31:0] offset;
    logic [31:0] dcset;
    logic        add_on;
    logic        add_off;
    logic        add_dc;
    logic        ignored;
  } cube_t;

  cube_t cube_q[$];
  cube_t want;

  // Shadow of the configuration registers
  logic [CNT_W-1:0] n_in;
  logic [CNT_W-1:0] n_out;
  logic             k_on;
  logic             k_off;
  logic             k_dc;

  // Shadow of the parser state
  phase_e      phase;
  int unsigned pos;
  logic [63:0] in_bits;
  logic [31:0] on_bits;
  logic [31:0] off_bits;
  logic [31:0] dc_bits;
  logic [2:0]  keep;

  // Map zero to one and hold the count at the limit
  function automatic int unsigned limit_count(logic [CNT_W-1:0] v, int unsigned ceiling);
    if (v == '0) return 1;
    if (32'(v) > ceiling) return ceiling;
    return 32'(v);
  endfunction

  function automatic logic is_blank_char(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, exp_val);
    mismatches_o++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // Queue a finished cube, or an error result when bad is set
  task automatic push_cube(logic bad);
    cube_t c_exp;
    c_exp.input_part = bad ? '0 : in_bits;
    c_exp.onset      = bad ? '0 : on_bits;
    c_exp.offset     = bad ? '0 : off_bits;
    c_exp.dcset      = bad ? '0 : dc_bits;
    c_exp.add_on     = !bad && keep[0];
    c_exp.add_off    = !bad && keep[1];
    c_exp.add_dc     = !bad && keep[2];
    c_exp.ignored    = bad;
    cube_q.push_back(c_exp);
  endtask

  // Advance the parser by one accepted item
  task automatic parse_char(logic [7:0] c, logic eoi);
    int unsigned ni;
    int unsigned no;
    logic [63:0] pair;
    logic [31:0] bit_m;
    ni = limit_count(n_in, INPUT_LIMIT);
    no = limit_count(n_out, OUTPUT_LIMIT);

    // End of stream drops an open cube and returns to idle
    if (eoi) begin
      if (phase == PH_IN || phase == PH_OUT) push_cube(1'b1);
      phase = PH_IDLE;
      pos = 0;
      return;
    end

    // Drop the rest of a comment, directive or bad line
    if (phase == PH_SKIP) begin
      if (c == CH_NL) phase = PH_IDLE;
      return;
    end

    if (phase == PH_IDLE) begin
      if (is_blank_char(c)) return;
      if (c == CH_HASH || c == CH_DOT) begin
        phase = PH_SKIP;
        return;
      end
      in_bits  = '0;
      on_bits  = '0;
      off_bits = '0;
      dc_bits  = '0;
      keep     = '0;
      pos      = 0;
      phase    = PH_IN;
    end

    if (is_blank_char(c) || c == CH_BAR) return;

    // Input part: two bits per variable
    if (phase == PH_IN) begin
      pair = (pos < ni) ? (64'd3 << (2 * pos)) : '0;
      case (c)
        CH_TWO, CH_DASH: in_bits |= pair;
        CH_ZERO:         in_bits |= pair & {32{2'b01}};
        CH_ONE:          in_bits |= pair & {32{2'b10}};
        CH_QUEST:        ;
        default: begin
          phase = PH_SKIP;
          push_cube(1'b1);
          return;
        end
      endcase
      pos++;
      if (pos >= ni) begin
        phase = PH_OUT;
        pos = 0;
      end
      return;
    end

    // Output part: one bit per position in the mask of its type
    bit_m = (pos < no) ? (32'd1 << pos) : '0;
    case (c)
      CH_ONE, CH_FOUR: begin
        if (k_on) begin
          on_bits |= bit_m;
          keep[0] = 1'b1;
        end
      end
      CH_ZERO, CH_THREE: begin
        if (k_off) begin
          off_bits |= bit_m;
          keep[1] = 1'b1;
        end
      end
      CH_TWO, CH_DASH: begin
        if (k_dc) begin
          dc_bits |= bit_m;
          keep[2] = 1'b1;
        end
      end
      CH_TILDE: ;
      default: begin
        phase = PH_SKIP;
        push_cube(1'b1);
        return;
      end
    endcase
    pos++;
    if (pos >= no) begin
      phase = PH_IDLE;
      pos = 0;
      push_cube(1'b0);
    end
  endtask

  // Compare results first, then apply writes, then predict the new item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_in         = RST_NUM_INPUTS;
      n_out        = RST_NUM_OUTPUTS;
      k_on         = 1'b1;
      k_off        = 1'b0;
      k_dc         = 1'b1;
      phase        = PH_IDLE;
      pos          = 0;
      in_bits      = '0;
      on_bits      = '0;
      off_bits     = '0;
      dc_bits      = '0;
      keep         = '0;
      cube_q.delete();
      cubes_due_o  = 0;
      mismatches_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cube_q.size() == 0) begin
          report_mismatch("result with no cube pending", input_part_i, '0);
        end else begin
          want = cube_q.pop_front();
          check_field("input_part", input_part_i, want.input_part);
          check_field("onset_mask", 64'(onset_mask_i), 64'(want.onset));
          check_field("offset_mask", 64'(offset_mask_i), 64'(want.offset));
          check_field("dcset_mask", 64'(dcset_mask_i), 64'(want.dcset));
          check_field("add_onset", 64'(add_onset_i), 64'(want.add_on));
          check_field("add_offset", 64'(add_offset_i), 64'(want.add_off));
          check_field("add_dcset", 64'(add_dcset_i), 64'(want.add_dc));
          check_field("line_ignored", 64'(line_ignored_i), 64'(want.ignored));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_INPUTS:  n_in  = cfg_data_i;
          CFG_NUM_OUTPUTS: n_out = cfg_data_i;
          CFG_KEEP_ONSET:  k_on  = cfg_data_i[0];
          CFG_KEEP_OFFSET: k_off = cfg_data_i[0];
          CFG_KEEP_DCSET:  k_dc  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) parse_char(char_in_i, end_of_input_i);
      cubes_due_o = cube_q.size();
    end
  end

endmodule

// ----- verif/pla_cube_line_parser_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PLA cube line parser regression
// Feeds directed and random PLA text through the parser in bursts while the
// result side stalls, over several cube sizes and type settings, and lets the
// checker compare every result.
// ----------------------------------------------------------------------------
module pla_cube_line_parser_test;
  import pclp_pkg::*;

  localparam int          LATENCY     = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [2:0]       cfg_idx_i;
  logic [CNT_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       char_in_i;
  logic             end_of_input_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [63:0]      input_part_o;
  logic [31:0]      onset_mask_o;
  logic [31:0]      offset_mask_o;
  logic [31:0]      dcset_mask_o;
  logic             add_onset_o;
  logic             add_offset_o;
  logic             add_dcset_o;
  logic             line_ignored_o;

  int          cubes_due;
  int          mismatches;
  int unsigned cycle_count = 0;
  int          burst_left  = 0;
  int          stall_left  = 0;
  int          stall_mode  = 0;
  int          items_sent  = 0;
  int          cur_ni;
  int          cur_no;

  // Directed items as {end_of_input, char}, with two inputs and two outputs
  logic [8:0] directed_items [0:24] = '{
    // comment line
    {1'b0, CH_HASH}, {1'b0, 8'h7A}, {1'b0, CH_NL},
    // cube with a don't-care and an unknown input, bar, on and off outputs
    {1'b0, CH_TWO}, {1'b0, CH_QUEST}, {1'b0, CH_BAR}, {1'b0, CH_FOUR}, {1'b0, CH_THREE},
    // leading tab, then a cube with dc output and tilde
    {1'b0, CH_TAB}, {1'b0, CH_ONE}, {1'b0, CH_ZERO}, {1'b0, CH_DASH}, {1'b0, CH_TILDE},
    // bad character as the first input
    {1'b0, 8'h78}, {1'b0, 8'h71}, {1'b0, CH_NL},
    // directive line
    {1'b0, CH_DOT}, {1'b0, CH_NL},
    // end of input inside a cube, then at idle
    {1'b0, CH_ONE}, {1'b1, 8'h00}, {1'b1, 8'hA5},
    // bad character in the output part
    {1'b0, CH_ZERO}, {1'b0, CH_ONE}, {1'b0, 8'hFF}, {1'b0, CH_NL}
  };

  pla_cube_line_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .input_part_o   (input_part_o),
    .onset_mask_o   (onset_mask_o),
    .offset_mask_o  (offset_mask_o),
    .dcset_mask_o   (dcset_mask_o),
    .add_onset_o    (add_onset_o),
    .add_offset_o   (add_offset_o),
    .add_dcset_o    (add_dcset_o),
    .line_ignored_o (line_ignored_o)
  );

  pla_cube_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .char_in_i      (char_in_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .input_part_i   (input_part_o),
    .onset_mask_i   (onset_mask_o),
    .offset_mask_i  (offset_mask_o),
    .dcset_mask_i   (dcset_mask_o),
    .add_onset_i    (add_onset_o),
    .add_offset_i   (add_offset_o),
    .add_dcset_i    (add_dcset_o),
    .line_ignored_i (line_ignored_o),
    .cubes_due_o    (cubes_due),
    .mismatches_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pla_cube_line_parser regression: fail");
      $finish;
    end
  end

  // Stall the result side in stretches: none, random, mostly stalled, periodic
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall_i = 1'b0;
      1:       out_stall_i = 1'($urandom_range(0, 1));
      2:       out_stall_i = ($urandom_range(0, 7) != 0);
      default: out_stall_i = (stall_left % 5) < 2;
    endcase
  end

  // Offer one item and hold it until accepted; gaps fall between bursts
  task automatic send_item(logic [7:0] ch, logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i     = 1'b1;
    char_in_i      = ch;
    end_of_input_i = eoi;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  function automatic logic [7:0] pick_input_char();
    case ($urandom_range(0, 4))
      0:       return CH_ZERO;
      1:       return CH_ONE;
      2:       return CH_DASH;
      3:       return CH_TWO;
      default: return CH_QUEST;
    endcase
  endfunction

  function automatic logic [7:0] pick_output_char();
    case ($urandom_range(0, 6))
      0:       return CH_ONE;
      1:       return CH_FOUR;
      2:       return CH_ZERO;
      3:       return CH_THREE;
      4:       return CH_DASH;
      5:       return CH_TWO;
      default: return CH_TILDE;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 6))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_NL;
      3:       return CH_VT;
      4:       return CH_FF;
      5:       return CH_CR;
      default: return CH_BAR;
    endcase
  endfunction

  // Send positions of one part, with separators now and then
  task automatic send_positions(int count, logic inputs_side);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 4) == 0) send_item(pick_blank(), 1'b0);
      send_item(inputs_side ? pick_input_char() : pick_output_char(), 1'b0);
    end
  endtask

  // Send one line: mostly good cubes, else broken, skipped, ended or noise
  task automatic send_line();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_positions(cur_ni, 1'b1);
      send_positions(cur_no, 1'b0);
      if ($urandom_range(0, 9) < 7) send_item(CH_NL, 1'b0);
    end else if (kind < 80) begin
      cut = $urandom_range(0, cur_ni + cur_no - 1);
      if (cut < cur_ni) begin
        send_positions(cut, 1'b1);
      end else begin
        send_positions(cur_ni, 1'b1);
        send_positions(cut - cur_ni, 1'b0);
      end
      send_item(8'($urandom_range(0, 255)), 1'b0);
      repeat ($urandom_range(0, 3)) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(CH_NL, 1'b0);
    end else if (kind < 86) begin
      send_item($urandom_range(0, 1) ? CH_HASH : CH_DOT, 1'b0);
      repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
      send_item(CH_NL, 1'b0);
    end else if (kind < 90) begin
      send_positions($urandom_range(0, 2), 1'b1);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  // Hold off until every expected cube has come and the pipeline is empty
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (cubes_due != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CNT_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_config(int ni, int no, logic kon, logic koff, logic kdc);
    drain_results();
    write_reg(CFG_NUM_INPUTS, CNT_W'(ni));
    write_reg(CFG_NUM_OUTPUTS, CNT_W'(no));
    write_reg(CFG_KEEP_ONSET, {5'($urandom), kon});
    write_reg(CFG_KEEP_OFFSET, {5'($urandom), koff});
    write_reg(CFG_KEEP_DCSET, {5'($urandom), kdc});
    cur_ni = (ni == 0) ? 1 : (ni > DEF_MAX_INPUTS) ? DEF_MAX_INPUTS : ni;
    cur_no = (no == 0) ? 1 : (no > DEF_MAX_OUTPUTS) ? DEF_MAX_OUTPUTS : no;
  endtask

  // Run random lines under one setting; may leave a cube open for the next one
  task automatic run_setting(int ni, int no, logic kon, logic koff, logic kdc, int budget);
    int start;
    set_config(ni, no, kon, koff, kdc);
    start = items_sent;
    while (items_sent - start < budget) send_line();
    send_positions($urandom_range(0, 3), 1'b1);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_NUM_INPUTS;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    char_in_i      = '0;
    end_of_input_i = 1'b0;
    out_stall_i    = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items with small cubes
    set_config(2, 2, 1'b1, 1'b1, 1'b1);
    foreach (directed_items[k]) send_item(directed_items[k][7:0], directed_items[k][8]);

    // Random text over several settings, extremes among them
    run_setting(1, 1, 1'b1, 1'b1, 1'b1, 120);
    run_setting(0, 0, 1'b1, 1'b0, 1'b1, 80);
    run_setting(32, 32, 1'b1, 1'b1, 1'b1, 100);
    run_setting(63, 5, 1'b0, 1'b1, 1'b0, 60);
    run_setting(5, 3, 1'b0, 1'b0, 1'b0, 80);
    run_setting(3, 4, 1'b1, 1'b1, 1'b1, 100);
    run_setting(8, 8, 1'b1, 1'b0, 1'b1, 80);
    repeat (2) begin
      run_setting($urandom_range(0, 6), $urandom_range(0, 6), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 80);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("pla_cube_line_parser regression: pass");
    end else begin
      $display("pla_cube_line_parser regression: fail");
    end
    $finish;
  end

endmodule
